// ===== src/i2c_seq_pkg.sv =====
package i2c_seq_pkg;

   // queue sizing and per-request byte limits
   localparam int QUEUE_DEPTH        = 16;
   localparam int MAX_DATA_BYTES     = 8;
   localparam int MAX_SUB_ADDR_BYTES = 4;
   localparam int PTR_W              = $clog2(QUEUE_DEPTH);
   localparam int CNT_W              = $clog2(QUEUE_DEPTH + 1);

   // request kinds (req_tuser)
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_EVENT   = 2'd1;
   localparam logic [1:0] REQ_BEGIN   = 2'd2;

   // bus actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_TX      = 3'd2;
   localparam logic [2:0] ACT_RESTART = 3'd3;
   localparam logic [2:0] ACT_RX      = 3'd4;
   localparam logic [2:0] ACT_ACK     = 3'd5;
   localparam logic [2:0] ACT_NACK    = 3'd6;
   localparam logic [2:0] ACT_STOP    = 3'd7;

   // enqueue status
   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOT_ENQ  = 2'd2;

   typedef struct packed {
      logic [7:0]  tag;
      logic [3:0]  data_cnt;
      logic [2:0]  sub_cnt;
      logic [31:0] sub_addr;
      logic        rd;
      logic [6:0]  addr;
   } hdr_type;

   function automatic logic [2:0] clamp_sub(input logic [2:0] c);
      logic [2:0] r;
      if (c == 3'd0) r = 3'd1;
      else if (c > 3'(MAX_SUB_ADDR_BYTES)) r = 3'(MAX_SUB_ADDR_BYTES);
      else r = c;
      return r;
   endfunction

   function automatic logic [3:0] clamp_data(input logic [3:0] c);
      logic [3:0] r;
      if (c == 4'd0) r = 4'd1;
      else if (c > 4'(MAX_DATA_BYTES)) r = 4'(MAX_DATA_BYTES);
      else r = c;
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

endpackage

// ===== src/i2c_master_transaction_sequencer_unit.sv =====
// I2C master register-transfer sequencer with a queue of pending requests.
// Input channel req_*: req_tuser carries the kind (enqueue, bus-done event,
// begin); req_tdata carries the request fields and the received byte.
// Result channel rsp_*: exactly one result per input transfer, in order,
// giving the next bus action, the byte to send, the enqueue status, the
// idle flag and, on the stop that ends a read, the completed read record
// (rsp_tuser high, tag, bytes and count in rsp_tdata).
// A transfer lands in the input register, and the sequencer and queue
// logic then update the state and load the result register. Throughput
// is one item per clock while the receiver takes results, limited only
// by the single input and result registers.
// The queue holds QUEUE_DEPTH requests in flops, written at the tail and
// read at the head; a full queue refuses an enqueue without change.
// Reset empties the queue, marks the sequencer stopped and idle and drops
// both registers. When the receiver stalls, the result register holds and
// the input register takes one more transfer; then req_tready falls until
// the result is taken.
module i2c_master_transaction_sequencer_unit
   import i2c_seq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [6:0] target_addr, [7] read_mode, [39:8] sub_addr,
   // [42:40] sub_addr_count, [106:43] tx_data, [110:107] data_count,
   // [118:111] request_tag, [126:119] rx_byte, [127] zero
   input  logic [127:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] bus_action, [10:3] tx_byte, [12:11] enqueue_status, [13] bus_idle,
   // [21:14] record_tag, [85:22] record_data, [89:86] record_count, [95:90] zero
   output logic [95:0]  rsp_tdata,
   // [0] record_valid
   output logic         rsp_tuser
);

   localparam logic [3:0] PH_STOPPED   = 4'd0;
   localparam logic [3:0] PH_STARTED   = 4'd1;
   localparam logic [3:0] PH_ADDR_W    = 4'd2;
   localparam logic [3:0] PH_SUB_DONE  = 4'd3;
   localparam logic [3:0] PH_DATA_TX   = 4'd4;
   localparam logic [3:0] PH_RESTARTED = 4'd5;
   localparam logic [3:0] PH_ADDR_R    = 4'd6;
   localparam logic [3:0] PH_DATA_RX   = 4'd7;
   localparam logic [3:0] PH_ACKED     = 4'd8;
   localparam logic [3:0] PH_NACKED    = 4'd9;

   // input register
   logic             s1_valid_ff, s1_valid_in;
   logic [1:0]       s1_kind_ff;
   hdr_type          s1_hdr_ff;
   logic [63:0]      s1_tx_ff;
   logic [7:0]       s1_rx_ff;

   // queue storage
   hdr_type          q_hdr_ff [QUEUE_DEPTH];
   logic [63:0]      q_pay_ff [QUEUE_DEPTH];
   logic             q_we;

   // sequencer state
   logic [3:0]       phase_ff, phase_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   hdr_type          cur_hdr_ff, cur_hdr_in;
   logic [63:0]      cur_pay_ff, cur_pay_in;
   logic [63:0]      rx_buf_ff, rx_buf_in;
   logic [2:0]       sub_idx_ff, sub_idx_in;
   logic [3:0]       byte_idx_ff, byte_idx_in;
   logic             idle_ff, idle_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic [2:0]       act_ff, act_in;
   logic [7:0]       txb_ff, txb_in;
   logic [1:0]       status_ff, status_in;
   logic             bus_idle_ff;
   logic             rec_valid_ff, rec_valid_in;
   logic [7:0]       rec_tag_ff, rec_tag_in;
   logic [63:0]      rec_data_ff, rec_data_in;
   logic [3:0]       rec_cnt_ff, rec_cnt_in;

   logic             advance;
   logic [3:0]       eff_phase;
   logic [2:0]       sub_inc;
   logic [3:0]       byte_inc;
   logic [3:0]       data_n;
   logic [63:0]      rx_masked;

   assign advance     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   assign eff_phase = (s1_kind_ff == REQ_BEGIN) ? PH_STOPPED : phase_ff;
   assign sub_inc   = sub_idx_ff + 3'd1;
   assign byte_inc  = byte_idx_ff + 4'd1;
   assign data_n    = clamp_data(cur_hdr_ff.data_cnt);

   // keep only the bytes that were received
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rx_masked[8*i +: 8] = (4'(i) < data_n) ? rx_buf_ff[8*i +: 8] : 8'd0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cur_hdr_in   = cur_hdr_ff;
      cur_pay_in   = cur_pay_ff;
      rx_buf_in    = rx_buf_ff;
      sub_idx_in   = sub_idx_ff;
      byte_idx_in  = byte_idx_ff;
      idle_in      = idle_ff;
      q_we         = 1'b0;
      act_in       = ACT_NONE;
      txb_in       = 8'd0;
      status_in    = ST_NOT_ENQ;
      rec_valid_in = 1'b0;
      rec_tag_in   = 8'd0;
      rec_data_in  = 64'd0;
      rec_cnt_in   = 4'd0;
      if (advance) begin
         case (s1_kind_ff)
            REQ_ENQUEUE: begin
               if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  q_we      = 1'b1;
                  tail_in   = next_ptr(tail_ff);
                  count_in  = count_ff + 1'b1;
                  status_in = ST_ACCEPTED;
               end
            end
            REQ_EVENT, REQ_BEGIN: begin
               case (eff_phase)
                  PH_STARTED: begin
                     act_in      = ACT_TX;
                     txb_in      = {cur_hdr_ff.addr, 1'b0};
                     sub_idx_in  = 3'd0;
                     byte_idx_in = 4'd0;
                     phase_in    = PH_ADDR_W;
                  end
                  PH_ADDR_W: begin
                     act_in     = ACT_TX;
                     txb_in     = cur_hdr_ff.sub_addr[8*sub_idx_ff[1:0] +: 8];
                     sub_idx_in = sub_inc;
                     if (sub_inc >= clamp_sub(cur_hdr_ff.sub_cnt)) phase_in = PH_SUB_DONE;
                  end
                  PH_SUB_DONE: begin
                     if (cur_hdr_ff.rd) begin
                        act_in   = ACT_RESTART;
                        phase_in = PH_RESTARTED;
                     end else begin
                        act_in   = ACT_TX;
                        txb_in   = cur_pay_ff[8*byte_idx_ff[2:0] +: 8];
                        phase_in = PH_DATA_TX;
                     end
                  end
                  PH_DATA_TX: begin
                     byte_idx_in = byte_inc;
                     if (byte_inc >= data_n) begin
                        act_in   = ACT_STOP;
                        phase_in = PH_STOPPED;
                     end else begin
                        act_in = ACT_TX;
                        txb_in = cur_pay_ff[8*byte_inc[2:0] +: 8];
                     end
                  end
                  PH_RESTARTED: begin
                     act_in   = ACT_TX;
                     txb_in   = {cur_hdr_ff.addr, 1'b1};
                     phase_in = PH_ADDR_R;
                  end
                  PH_ADDR_R, PH_ACKED: begin
                     act_in   = ACT_RX;
                     phase_in = PH_DATA_RX;
                  end
                  PH_DATA_RX: begin
                     rx_buf_in[8*byte_idx_ff[2:0] +: 8] = s1_rx_ff;
                     byte_idx_in = byte_inc;
                     if (byte_inc >= data_n) begin
                        act_in   = ACT_NACK;
                        phase_in = PH_NACKED;
                     end else begin
                        act_in   = ACT_ACK;
                        phase_in = PH_ACKED;
                     end
                  end
                  PH_NACKED: begin
                     act_in       = ACT_STOP;
                     rec_valid_in = 1'b1;
                     rec_tag_in   = cur_hdr_ff.tag;
                     rec_data_in  = rx_masked;
                     rec_cnt_in   = data_n;
                     phase_in     = PH_STOPPED;
                  end
                  default: begin
                     // stopped: take the next request, or report idle
                     if (count_ff == '0) begin
                        idle_in  = 1'b1;
                        phase_in = PH_STOPPED;
                     end else begin
                        cur_hdr_in = q_hdr_ff[head_ff];
                        cur_pay_in = q_pay_ff[head_ff];
                        head_in    = next_ptr(head_ff);
                        count_in   = count_ff - 1'b1;
                        rx_buf_in  = 64'd0;
                        act_in     = ACT_START;
                        idle_in    = 1'b0;
                        phase_in   = PH_STARTED;
                     end
                  end
               endcase
            end
            default: begin
               // unknown kind: drop, result carries only status and idle
            end
         endcase
      end
   end

   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_STOPPED;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cur_hdr_ff   <= '0;
         cur_pay_ff   <= 64'd0;
         rx_buf_ff    <= 64'd0;
         sub_idx_ff   <= 3'd0;
         byte_idx_ff  <= 4'd0;
         idle_ff      <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cur_hdr_ff   <= cur_hdr_in;
         cur_pay_ff   <= cur_pay_in;
         rx_buf_ff    <= rx_buf_in;
         sub_idx_ff   <= sub_idx_in;
         byte_idx_ff  <= byte_idx_in;
         idle_ff      <= idle_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff        <= req_tuser;
         s1_hdr_ff.addr     <= req_tdata[6:0];
         s1_hdr_ff.rd       <= req_tdata[7];
         s1_hdr_ff.sub_addr <= req_tdata[39:8];
         s1_hdr_ff.sub_cnt  <= req_tdata[42:40];
         s1_tx_ff           <= req_tdata[106:43];
         s1_hdr_ff.data_cnt <= req_tdata[110:107];
         s1_hdr_ff.tag      <= req_tdata[118:111];
         s1_rx_ff           <= req_tdata[126:119];
      end
      if (q_we) begin
         q_hdr_ff[tail_ff] <= s1_hdr_ff;
         q_pay_ff[tail_ff] <= s1_tx_ff;
      end
      if (advance) begin
         act_ff       <= act_in;
         txb_ff       <= txb_in;
         status_ff    <= status_in;
         bus_idle_ff  <= idle_in;
         rec_valid_ff <= rec_valid_in;
         rec_tag_ff   <= rec_tag_in;
         rec_data_ff  <= rec_data_in;
         rec_cnt_ff   <= rec_cnt_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rec_valid_ff;
   assign rsp_tdata  = {6'd0, rec_cnt_ff, rec_data_ff, rec_tag_ff, bus_idle_ff,
                        status_ff, txb_ff, act_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_record_on_stop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rec_valid_ff) |-> (act_ff == ACT_STOP))
      else $error("read record without stop");

   a_busy_when_acting: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && act_ff != ACT_NONE) |-> !bus_idle_ff)
      else $error("bus action while reported idle");

endmodule
